/* sv/hsv2rgb_pkg.sv */
// Shared types, constants and tables for the HSV to RGB PWM converter.
package hsv2rgb_pkg;

  localparam int HUE_W      = 9;
  localparam int LEVEL_W    = 13;
  localparam int LEVEL_BITS = 12;
  localparam int LEVEL_ONE  = 4096;

  localparam int FRAC_BITS  = 12;
  localparam int ONE_F      = 1 << FRAC_BITS;

  localparam int SECTOR_DEG = 60;
  localparam int SECTOR_NUM = 6;
  localparam int HUE_LIMIT  = SECTOR_DEG * SECTOR_NUM;
  localparam int REM_W      = $clog2(SECTOR_DEG);
  localparam int FRAC_LUT_DEPTH = 1 << REM_W;

  localparam int PROD_W     = 2 * (LEVEL_W + 1);
  localparam int SF_PROD_W  = LEVEL_W + FRAC_BITS;
  localparam int SFC_PROD_W = SF_PROD_W + 1;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    SECT_R_TO_Y = 3'd0,
    SECT_Y_TO_G = 3'd1,
    SECT_G_TO_C = 3'd2,
    SECT_C_TO_B = 3'd3,
    SECT_B_TO_M = 3'd4,
    SECT_M_TO_R = 3'd5
  } sector_t;

  typedef logic [FRAC_LUT_DEPTH-1:0][FRAC_BITS-1:0] frac_lut_t;

  // Classified word passed from the front end to the arithmetic back end.
  typedef struct packed {
    logic                 blank;
    sector_t              sector;
    logic [FRAC_BITS-1:0] frac;
    logic [LEVEL_W-1:0]   sat;
    logic [LEVEL_W-1:0]   bri;
  } item_t;

  typedef struct packed {
    logic               blank;
    sector_t            sector;
    logic [LEVEL_W-1:0] sat;
    logic [LEVEL_W-1:0] bri;
    logic [LEVEL_W-1:0] sf;
    logic [LEVEL_W-1:0] sfc;
  } stage1_t;

  typedef struct packed {
    logic                     blank;
    sector_t                  sector;
    logic [LEVEL_W-1:0]       vv;
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_q;
    logic signed [PROD_W-1:0] prod_t;
  } stage2_t;

  // Fraction within a sector, (rem << FRAC_BITS) / 60, truncated.
  function automatic frac_lut_t build_frac_lut();
    frac_lut_t lut;
    for (int i = 0; i < FRAC_LUT_DEPTH; i++) begin
      if (i < SECTOR_DEG) begin
        lut[i] = FRAC_BITS'((i << FRAC_BITS) / SECTOR_DEG);
      end else begin
        lut[i] = '0;
      end
    end
    return lut;
  endfunction

  localparam frac_lut_t FRAC_LUT = build_frac_lut();

endpackage

/* sv/hsv2rgb_ifs.sv */
// Valid/ready channel interfaces for the HSV input and the RGB result words.
interface hsv2rgb_in_if;
  logic                             valid;
  logic                             ready;
  logic [hsv2rgb_pkg::HUE_W-1:0]    hue;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]  saturation;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if;
  logic                             valid;
  logic                             ready;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]  red;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]  green;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

/* sv/hsv_to_rgb_12bit_pwm_unit.sv */
// Top level of the HSV to RGB converter for 12-bit PWM channels.
// The unit converts one HSV word per clock cycle into red, green and blue PWM
// levels from 0 to 4096, with no state carried between words. A word passes
// through the classifying front end, the two-entry queue and the two multiplier
// stages of the back end before the output register. The steady rate of one word
// per cycle, when the output is not stalled, is set by the back end, whose five
// multipliers each work once per word. Hues from 360 to 511 give black.
// Saturation above 4096 drives negative levels to zero, and levels above 4096
// clamp to 4096.
module hsv_to_rgb_12bit_pwm_unit (
  input  logic            clk,
  input  logic            rst_n,
  hsv2rgb_in_if.sink      in_word,
  hsv2rgb_out_if.source   out_word
);

  hsv2rgb_pkg::item_t  front_item;
  logic                front_valid;
  logic                front_ready;
  hsv2rgb_pkg::item_t  queue_item;
  logic                queue_valid;
  logic                queue_ready;

  hsv2rgb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_word      (in_word),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  hsv2rgb_fifo u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (queue_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  hsv2rgb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (queue_item),
    .item_valid_i (queue_valid),
    .item_ready_o (queue_ready),
    .out_word     (out_word)
  );

endmodule

/* sv/hsv2rgb_front.sv */
// Front end: accepts HSV words, finds the hue sector and the fraction within it.
module hsv2rgb_front (
  input  logic                clk,
  input  logic                rst_n,
  hsv2rgb_in_if.sink          in_word,
  output hsv2rgb_pkg::item_t  item_o,
  output logic                item_valid_o,
  input  logic                item_ready_i
);

  logic                                 valid_r;
  hsv2rgb_pkg::item_t                   item_r;
  hsv2rgb_pkg::item_t                   item_nxt;
  logic                                 blank;
  logic [2:0]                           sector_idx;
  logic [hsv2rgb_pkg::HUE_W-1:0]        base;
  logic [hsv2rgb_pkg::REM_W-1:0]        rem;

  assign in_word.ready = !valid_r || item_ready_i;

  always_comb begin
    blank      = in_word.hue >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_LIMIT);
    sector_idx = '0;
    for (int i = 1; i < hsv2rgb_pkg::SECTOR_NUM; i++) begin
      if (in_word.hue >= hsv2rgb_pkg::HUE_W'(i * hsv2rgb_pkg::SECTOR_DEG)) begin
        sector_idx = 3'(i);
      end
    end
    base = hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_DEG) * hsv2rgb_pkg::HUE_W'(sector_idx);
    if (blank) begin
      rem = '0;
    end else begin
      rem = hsv2rgb_pkg::REM_W'(in_word.hue - base);
    end
    item_nxt.blank  = blank;
    item_nxt.sector = hsv2rgb_pkg::sector_t'(sector_idx);
    item_nxt.frac   = hsv2rgb_pkg::FRAC_LUT[rem];
    item_nxt.sat    = in_word.saturation;
    item_nxt.bri    = in_word.brightness;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_word.ready) begin
      valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.valid && in_word.ready) begin
      item_r <= item_nxt;
    end
  end

  assign item_o       = item_r;
  assign item_valid_o = valid_r;

endmodule

/* sv/hsv2rgb_fifo.sv */
// Short queue that decouples the classifying front end from the arithmetic back end.
module hsv2rgb_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  hsv2rgb_pkg::item_t  push_item_i,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  output hsv2rgb_pkg::item_t  pop_item_o,
  output logic                pop_valid_o,
  input  logic                pop_ready_i
);

  hsv2rgb_pkg::item_t                mem [hsv2rgb_pkg::QDEPTH];
  logic [hsv2rgb_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [hsv2rgb_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [hsv2rgb_pkg::QCNT_W-1:0]    count_r;
  logic [hsv2rgb_pkg::QCNT_W-1:0]    count_nxt;
  logic                              push;
  logic                              pop;

  assign push_ready_o = count_r != hsv2rgb_pkg::QCNT_W'(hsv2rgb_pkg::QDEPTH);
  assign pop_valid_o  = count_r != '0;
  assign pop_item_o   = mem[rd_ptr_r];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == hsv2rgb_pkg::QPTR_W'(hsv2rgb_pkg::QDEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == hsv2rgb_pkg::QPTR_W'(hsv2rgb_pkg::QDEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item_i;
    end
  end

endmodule

/* sv/hsv2rgb_back.sv */
// Back end: three-stage pipeline that forms p, q and t and routes them to RGB.
module hsv2rgb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hsv2rgb_pkg::item_t  item_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  hsv2rgb_out_if.source       out_word
);

  logic                                   s1_valid_r;
  logic                                   s2_valid_r;
  logic                                   out_valid_r;
  logic                                   s1_rdy;
  logic                                   s2_rdy;
  logic                                   out_rdy;
  hsv2rgb_pkg::stage1_t                   s1_r;
  hsv2rgb_pkg::stage1_t                   s1_nxt;
  hsv2rgb_pkg::stage2_t                   s2_r;
  hsv2rgb_pkg::stage2_t                   s2_nxt;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]        red_r;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]        green_r;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]        blue_r;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]        red_nxt;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]        green_nxt;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]        blue_nxt;
  logic [hsv2rgb_pkg::SF_PROD_W-1:0]      sf_prod;
  logic [hsv2rgb_pkg::SFC_PROD_W-1:0]     sfc_prod;
  logic [hsv2rgb_pkg::FRAC_BITS:0]        frac_c;
  logic signed [hsv2rgb_pkg::LEVEL_W:0]   bri_s;
  logic signed [hsv2rgb_pkg::LEVEL_W:0]   k_p;
  logic signed [hsv2rgb_pkg::LEVEL_W:0]   k_q;
  logic signed [hsv2rgb_pkg::LEVEL_W:0]   k_t;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]        lvl_p;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]        lvl_q;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]        lvl_t;

  // Positive products are floored to Q12 and clamped to full scale.
  function automatic logic [hsv2rgb_pkg::LEVEL_W-1:0] level_clip(
    input logic signed [hsv2rgb_pkg::PROD_W-1:0] prod
  );
    logic [hsv2rgb_pkg::PROD_W-2-hsv2rgb_pkg::LEVEL_BITS:0] shifted;
    shifted = prod[hsv2rgb_pkg::PROD_W-2:hsv2rgb_pkg::LEVEL_BITS];
    if (prod <= 0) begin
      return '0;
    end else if (shifted > ($bits(shifted))'(hsv2rgb_pkg::LEVEL_ONE)) begin
      return hsv2rgb_pkg::LEVEL_W'(hsv2rgb_pkg::LEVEL_ONE);
    end else begin
      return shifted[hsv2rgb_pkg::LEVEL_W-1:0];
    end
  endfunction

  assign out_rdy      = !out_valid_r || out_word.ready;
  assign s2_rdy       = !s2_valid_r || out_rdy;
  assign s1_rdy       = !s1_valid_r || s2_rdy;
  assign item_ready_o = s1_rdy;

  always_comb begin
    frac_c   = (hsv2rgb_pkg::FRAC_BITS + 1)'(hsv2rgb_pkg::ONE_F) - {1'b0, item_i.frac};
    sf_prod  = hsv2rgb_pkg::SF_PROD_W'(item_i.sat) *
               hsv2rgb_pkg::SF_PROD_W'(item_i.frac);
    sfc_prod = hsv2rgb_pkg::SFC_PROD_W'(item_i.sat) *
               hsv2rgb_pkg::SFC_PROD_W'(frac_c);
    s1_nxt.blank  = item_i.blank;
    s1_nxt.sector = item_i.sector;
    s1_nxt.sat    = item_i.sat;
    s1_nxt.bri    = item_i.bri;
    s1_nxt.sf     = sf_prod[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::LEVEL_W];
    s1_nxt.sfc    = sfc_prod[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::LEVEL_W];
  end

  always_comb begin
    bri_s = $signed({1'b0, s1_r.bri});
    k_p   = (hsv2rgb_pkg::LEVEL_W + 1)'(hsv2rgb_pkg::LEVEL_ONE) - $signed({1'b0, s1_r.sat});
    k_q   = (hsv2rgb_pkg::LEVEL_W + 1)'(hsv2rgb_pkg::LEVEL_ONE) - $signed({1'b0, s1_r.sf});
    k_t   = (hsv2rgb_pkg::LEVEL_W + 1)'(hsv2rgb_pkg::LEVEL_ONE) - $signed({1'b0, s1_r.sfc});
    s2_nxt.blank  = s1_r.blank;
    s2_nxt.sector = s1_r.sector;
    if (s1_r.bri > hsv2rgb_pkg::LEVEL_W'(hsv2rgb_pkg::LEVEL_ONE)) begin
      s2_nxt.vv = hsv2rgb_pkg::LEVEL_W'(hsv2rgb_pkg::LEVEL_ONE);
    end else begin
      s2_nxt.vv = s1_r.bri;
    end
    s2_nxt.prod_p = hsv2rgb_pkg::PROD_W'(bri_s) * hsv2rgb_pkg::PROD_W'(k_p);
    s2_nxt.prod_q = hsv2rgb_pkg::PROD_W'(bri_s) * hsv2rgb_pkg::PROD_W'(k_q);
    s2_nxt.prod_t = hsv2rgb_pkg::PROD_W'(bri_s) * hsv2rgb_pkg::PROD_W'(k_t);
  end

  always_comb begin
    lvl_p     = level_clip(s2_r.prod_p);
    lvl_q     = level_clip(s2_r.prod_q);
    lvl_t     = level_clip(s2_r.prod_t);
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (!s2_r.blank) begin
      unique case (s2_r.sector)
        hsv2rgb_pkg::SECT_R_TO_Y: begin
          red_nxt = s2_r.vv; green_nxt = lvl_t;   blue_nxt = lvl_p;
        end
        hsv2rgb_pkg::SECT_Y_TO_G: begin
          red_nxt = lvl_q;   green_nxt = s2_r.vv; blue_nxt = lvl_p;
        end
        hsv2rgb_pkg::SECT_G_TO_C: begin
          red_nxt = lvl_p;   green_nxt = s2_r.vv; blue_nxt = lvl_t;
        end
        hsv2rgb_pkg::SECT_C_TO_B: begin
          red_nxt = lvl_p;   green_nxt = lvl_q;   blue_nxt = s2_r.vv;
        end
        hsv2rgb_pkg::SECT_B_TO_M: begin
          red_nxt = lvl_t;   green_nxt = lvl_p;   blue_nxt = s2_r.vv;
        end
        hsv2rgb_pkg::SECT_M_TO_R: begin
          red_nxt = s2_r.vv; green_nxt = lvl_p;   blue_nxt = lvl_q;
        end
        default: begin
          red_nxt = '0;      green_nxt = '0;      blue_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_r <= item_valid_i;
      end
      if (s2_rdy) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_rdy) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_i && s1_rdy) begin
      s1_r <= s1_nxt;
    end
    if (s1_valid_r && s2_rdy) begin
      s2_r <= s2_nxt;
    end
    if (s2_valid_r && out_rdy) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_word.valid = out_valid_r;
  assign out_word.red   = red_r;
  assign out_word.green = green_r;
  assign out_word.blue  = blue_r;

endmodule
